// ===== sv/slrm_pkg.sv =====
// slrm_pkg: shared codes, reset values and the standard rate table for the
// s/pdif lock and rate monitor
// no dependencies
package slrm_pkg;

    // request kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_POLL  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // receiver lock states
    localparam logic [1:0] RUN_INACTIVE  = 2'd0;
    localparam logic [1:0] RUN_ACQUIRING = 2'd1;
    localparam logic [1:0] RUN_LOCKED    = 2'd2;
    localparam logic [1:0] RUN_RELOCKING = 2'd3;

    // configuration register indexes
    localparam logic REG_KERNEL_CLOCK = 1'b0;
    localparam logic REG_RETRY_INTERVAL = 1'b1;

    localparam int KCLK_W  = 27;
    localparam int RETRY_W = 16;
    localparam int WIDTH_W = 15;
    localparam int RATE_W  = 24;
    localparam int CFG_W   = 27;

    localparam logic [KCLK_W-1:0]  KCLK_RESET  = 27'd98304000;
    localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd100;

    localparam logic [7:0] TALLY_MAX = 8'hFF;

    // quotient bits produced by the serial divider
    localparam int DIV_STEPS = RATE_W;
    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    // standard rates and their 2 percent capture bands
    localparam int NUM_STD = 7;
    localparam logic [2:0] STD_LAST = 3'(NUM_STD - 1);
    localparam logic [RATE_W-1:0] STD_RATE [NUM_STD] = '{
        24'd32000, 24'd44100, 24'd48000, 24'd88200, 24'd96000, 24'd176400, 24'd192000
    };
    localparam logic [RATE_W-1:0] STD_LO [NUM_STD] = '{
        24'd31360, 24'd43218, 24'd47040, 24'd86436, 24'd94080, 24'd172872, 24'd188160
    };
    localparam logic [RATE_W-1:0] STD_HI [NUM_STD] = '{
        24'd32640, 24'd44982, 24'd48960, 24'd89964, 24'd97920, 24'd179928, 24'd195840
    };

endpackage

// ===== sv/slrm_if.sv =====
// slrm_in_if / slrm_out_if: valid-ready channels for requests and results
// of the lock and rate monitor; no dependencies
interface slrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        sync_error;
    logic        sync_done;
    logic [14:0] symbol_width;
    logic [31:0] now_ms;

    modport source (output valid, kind, sync_error, sync_done, symbol_width, now_ms,
                    input ready);
    modport sink (input valid, kind, sync_error, sync_done, symbol_width, now_ms,
                  output ready);
endinterface

interface slrm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  lock_state;
    logic [7:0]  locks_seen;
    logic [7:0]  losses_seen;
    logic [23:0] reported_rate_hz;
    logic        restart_sync;
    logic        enter_receive;

    modport source (output valid, lock_state, locks_seen, losses_seen, reported_rate_hz,
                    restart_sync, enter_receive, input ready);
    modport sink (input valid, lock_state, locks_seen, losses_seen, reported_rate_hz,
                  restart_sync, enter_receive, output ready);
endinterface

// ===== sv/spdif_lock_and_rate_monitor.sv =====
// spdif_lock_and_rate_monitor: lock state tracking and sample rate measurement
// depends on slrm_pkg and the channels in slrm_if.sv
//
// takes one request at a time (start, stop, status poll, error event) and
// answers each with exactly one result carrying the lock state, the saturating
// lock and loss counts, the measured rate and the restart / receive pulses.
// a request that does not measure the rate shows its result on the cycle after
// accept. a poll that reports sync done with a nonzero symbol width measures
// the rate as 5*kclk/(width*64) on a restoring divider producing one quotient
// bit per cycle, then walks the seven standard rates one per cycle to snap
// within 2 percent.
// the divider sets the cost. i_in.ready is high only while no request is in
// flight; the result is held on o_out until taken. configuration writes
// belong to idle periods.
module spdif_lock_and_rate_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    slrm_in_if.sink                           i_in,
    slrm_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [slrm_pkg::CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SNAP,
        S_OUT
    } t_seq_state;

    // sequencer and lock bookkeeping
    t_seq_state r_state, n_state;
    logic [1:0]  r_run, n_run;
    logic [7:0]  r_locks, n_locks;
    logic [7:0]  r_losses, n_losses;
    logic [slrm_pkg::RATE_W-1:0] r_rate, n_rate;
    logic [31:0] r_last_retry, n_last_retry;
    logic        r_restart, n_restart;
    logic        r_enter, n_enter;

    // configuration
    logic [slrm_pkg::KCLK_W-1:0]  r_kclk;
    logic [slrm_pkg::RETRY_W-1:0] r_retry;

    // divider datapath: quotient shifts in where the dividend shifts out
    logic [slrm_pkg::RATE_W-1:0]  r_quo, n_quo;
    logic [slrm_pkg::WIDTH_W-1:0] r_rem, n_rem;
    logic [slrm_pkg::WIDTH_W-1:0] r_width, n_width;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_idx, n_idx;

    logic        w_accept;
    logic [29:0] w_num;
    logic [31:0] w_elapsed;
    logic        w_retry_ok;
    logic [15:0] w_rem_sh;
    logic [15:0] w_den;
    logic [15:0] w_sub;
    logic        w_ge;
    logic        w_in_band;

    assign w_accept = i_in.valid && i_in.ready;

    // 5 * kclk, the /64 is taken by dropping six low bits
    assign w_num = {1'b0, r_kclk, 2'b00} + {3'b000, r_kclk};

    // wrapping millisecond distance since the last restart
    assign w_elapsed  = i_in.now_ms - r_last_retry;
    assign w_retry_ok = (r_last_retry == 32'd0) || (w_elapsed >= {16'd0, r_retry});

    // one restoring step
    assign w_rem_sh = {r_rem, r_quo[slrm_pkg::RATE_W-1]};
    assign w_den    = {1'b0, r_width};
    assign w_ge     = w_rem_sh >= w_den;
    assign w_sub    = w_rem_sh - w_den;

    // one band compare per cycle against the rate table
    assign w_in_band = (r_quo >= slrm_pkg::STD_LO[r_idx]) &&
                       (r_quo <= slrm_pkg::STD_HI[r_idx]);

    always_comb begin
        n_state      = r_state;
        n_run        = r_run;
        n_locks      = r_locks;
        n_losses     = r_losses;
        n_rate       = r_rate;
        n_last_retry = r_last_retry;
        n_restart    = r_restart;
        n_enter      = r_enter;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_width      = r_width;
        n_cnt        = r_cnt;
        n_idx        = r_idx;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_restart = 1'b0;
                    n_enter   = 1'b0;
                    n_state   = S_OUT;
                    case (i_in.kind)
                        slrm_pkg::KIND_START: begin
                            // a start while running is ignored
                            if (r_run == slrm_pkg::RUN_INACTIVE) begin
                                n_locks      = 8'd0;
                                n_losses     = 8'd0;
                                n_last_retry = 32'd0;
                                n_run        = slrm_pkg::RUN_ACQUIRING;
                            end
                        end
                        slrm_pkg::KIND_STOP: begin
                            if (r_run != slrm_pkg::RUN_INACTIVE) begin
                                n_run  = slrm_pkg::RUN_INACTIVE;
                                n_rate = '0;
                            end
                        end
                        slrm_pkg::KIND_POLL: begin
                            if (r_run != slrm_pkg::RUN_INACTIVE) begin
                                if (i_in.sync_error) begin
                                    // error wins over sync done
                                    if (r_run == slrm_pkg::RUN_LOCKED) begin
                                        n_run = slrm_pkg::RUN_RELOCKING;
                                        if (r_losses != slrm_pkg::TALLY_MAX) begin
                                            n_losses = r_losses + 8'd1;
                                        end
                                    end
                                    // after a loss the state is acquiring or relocking
                                    if (w_retry_ok) begin
                                        n_last_retry = i_in.now_ms;
                                        n_restart    = 1'b1;
                                    end
                                end else if (i_in.sync_done) begin
                                    if (r_run != slrm_pkg::RUN_LOCKED) begin
                                        n_enter = 1'b1;
                                        n_run   = slrm_pkg::RUN_LOCKED;
                                        if (r_locks != slrm_pkg::TALLY_MAX) begin
                                            n_locks = r_locks + 8'd1;
                                        end
                                    end
                                    // zero width keeps the old rate
                                    if (i_in.symbol_width != '0) begin
                                        n_quo   = w_num[29:6];
                                        n_rem   = '0;
                                        n_width = i_in.symbol_width;
                                        n_cnt   = 5'd0;
                                        n_state = S_DIV;
                                    end
                                end
                            end
                        end
                        slrm_pkg::KIND_ERROR: begin
                            if (r_run == slrm_pkg::RUN_LOCKED) begin
                                n_run = slrm_pkg::RUN_RELOCKING;
                                if (r_losses != slrm_pkg::TALLY_MAX) begin
                                    n_losses = r_losses + 8'd1;
                                end
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_rem = w_ge ? w_sub[slrm_pkg::WIDTH_W-1:0]
                             : w_rem_sh[slrm_pkg::WIDTH_W-1:0];
                n_quo = {r_quo[slrm_pkg::RATE_W-2:0], w_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == slrm_pkg::DIV_LAST) begin
                    n_idx   = 3'd0;
                    n_state = S_SNAP;
                end
            end
            S_SNAP: begin
                if (w_in_band) begin
                    n_rate  = slrm_pkg::STD_RATE[r_idx];
                    n_state = S_OUT;
                end else if (r_idx == slrm_pkg::STD_LAST) begin
                    // no standard rate near: report the raw measurement
                    n_rate  = r_quo;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run        <= slrm_pkg::RUN_INACTIVE;
            r_locks      <= 8'd0;
            r_losses     <= 8'd0;
            r_rate       <= '0;
            r_last_retry <= 32'd0;
            r_restart    <= 1'b0;
            r_enter      <= 1'b0;
            r_kclk       <= slrm_pkg::KCLK_RESET;
            r_retry      <= slrm_pkg::RETRY_RESET;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_locks      <= n_locks;
            r_losses     <= n_losses;
            r_rate       <= n_rate;
            r_last_retry <= n_last_retry;
            r_restart    <= n_restart;
            r_enter      <= n_enter;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    slrm_pkg::REG_KERNEL_CLOCK: r_kclk <= i_cfg_data[slrm_pkg::KCLK_W-1:0];
                    slrm_pkg::REG_RETRY_INTERVAL: r_retry <= i_cfg_data[slrm_pkg::RETRY_W-1:0];
                    default: r_retry <= r_retry;
                endcase
            end
        end
        // datapath registers need no reset
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_width <= n_width;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
    end

    assign i_in.ready = (r_state == S_IDLE);

    // the result is read straight from the bookkeeping, which stays put until taken
    assign o_out.valid            = (r_state == S_OUT);
    assign o_out.lock_state       = r_run;
    assign o_out.locks_seen       = r_locks;
    assign o_out.losses_seen      = r_losses;
    assign o_out.reported_rate_hz = (r_run == slrm_pkg::RUN_LOCKED) ? r_rate : '0;
    assign o_out.restart_sync     = r_restart;
    assign o_out.enter_receive    = r_enter;

endmodule

// ===== sv/slrm_checker.sv =====
// slrm_checker: port level assertions for the lock and rate monitor
// depends on slrm_pkg; bound to spdif_lock_and_rate_monitor below
module slrm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_lock_state,
    input logic [23:0] i_rate,
    input logic        i_restart,
    input logic        i_enter
);

    // one request in flight: no new request right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // entering receive mode only ever comes with lock
    a_enter_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_enter) |-> (i_lock_state == slrm_pkg::RUN_LOCKED))
        else $error("enter_receive without lock");

    // a sync restart is requested only while acquiring or relocking
    a_restart_unlocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_restart) |->
            (i_lock_state == slrm_pkg::RUN_ACQUIRING ||
             i_lock_state == slrm_pkg::RUN_RELOCKING))
        else $error("restart_sync outside acquire or relock");

    // a nonzero rate is reported only when locked
    a_rate_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_rate != 24'd0)) |-> (i_lock_state == slrm_pkg::RUN_LOCKED))
        else $error("rate reported while not locked");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn before taken");

endmodule

bind spdif_lock_and_rate_monitor slrm_checker u_slrm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_lock_state(o_out.lock_state),
    .i_rate      (o_out.reported_rate_hz),
    .i_restart   (o_out.restart_sync),
    .i_enter     (o_out.enter_receive)
);
